// ----- rtl/cmd_pkg.sv -----
package cmd_pkg;

  localparam int MAX_DELAY = 4096;
  localparam int CHANNELS  = 2;

  localparam int AW       = $clog2(MAX_DELAY);
  localparam int RING_W   = AW + 1;
  localparam int SAMPLE_W = 16;
  localparam int BASE_W   = 12;
  localparam int DEPTH_W  = 19;
  localparam int STEP_W   = 31;
  localparam int GAIN_W   = 15;
  localparam int MIX_W    = 16;
  localparam int MIXC_W   = MIX_W + 1;
  localparam int RLEN_W   = 13;
  localparam int PHASE_W  = 32;
  localparam int FRAC_W   = 8;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam int D8_W     = 22;
  localparam int POS_W    = ((AW + FRAC_W > D8_W) ? AW + FRAC_W : D8_W) + 1;
  localparam int IPOS_W   = POS_W - FRAC_W;
  localparam int WR_ITER  = (IPOS_W + 1) / 2;
  localparam int WR_STEPS = 2 * WR_ITER;
  localparam int CMP_W    = RING_W + WR_STEPS;
  localparam int CNT_W    = $clog2(WR_ITER);

  localparam logic [MIXC_W-1:0] MIX_ONE = MIXC_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = CFG_IDX_W'(5);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [AW-1:0] rd_addr;
    logic          cap_s1;
    logic          interp;
    logic          fb;
    logic          we;
    logic          clr;
    logic [AW-1:0] wr_addr;
  } lane_ctl_t;

  typedef struct packed {
    logic          done;
    logic          neg;
    logic [AW-1:0] rem;
  } wrap_res_t;

  localparam logic signed [15:0] QUARTER_SINE [0:64] = '{
    16'sd0,     16'sd804,   16'sd1608,  16'sd2410,  16'sd3212,  16'sd4011,
    16'sd4808,  16'sd5602,  16'sd6393,  16'sd7179,  16'sd7962,  16'sd8739,
    16'sd9512,  16'sd10278, 16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279,
    16'sd14010, 16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530,
    16'sd18204, 16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403,
    16'sd22005, 16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811,
    16'sd25329, 16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683,
    16'sd28105, 16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956,
    16'sd30273, 16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580,
    16'sd31785, 16'sd31971, 16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521,
    16'sd32609, 16'sd32678, 16'sd32728, 16'sd32757, 16'sd32767
  };

  function automatic logic signed [15:0] lfo_sine(input logic [7:0] idx);
    logic [5:0] j;
    logic [6:0] jm;
    logic signed [15:0] v;
    j  = idx[5:0];
    jm = 7'd64 - {1'b0, j};
    unique case (idx[7:6])
      2'd0: v = QUARTER_SINE[j];
      2'd1: v = QUARTER_SINE[jm];
      2'd2: v = -QUARTER_SINE[j];
      default: v = -QUARTER_SINE[jm];
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/cmd_ram.sv -----
module cmd_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [0:DEPTH-1];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cmd_wrap.sv -----
module cmd_wrap (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [cmd_pkg::IPOS_W-1:0]  ipos,
  input  logic [cmd_pkg::RING_W-1:0]         ring,
  output cmd_pkg::wrap_res_t                 res
);
  import cmd_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [IPOS_W-1:0] rem_r;
  logic [CMP_W-1:0]  div_r;

  logic [IPOS_W-1:0] mag;
  logic [CMP_W-1:0]  d_hi;
  logic [CMP_W-1:0]  rem_ext;
  logic [CMP_W-1:0]  r1;
  logic [CMP_W-1:0]  r2;

  // two restoring steps per cycle
  always_comb begin
    mag     = ipos[IPOS_W-1] ? IPOS_W'(-ipos) : IPOS_W'(ipos);
    d_hi    = div_r << 1;
    rem_ext = CMP_W'(rem_r);
    r1      = (rem_ext >= d_hi) ? rem_ext - d_hi : rem_ext;
    r2      = (r1 >= div_r) ? r1 - div_r : r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WR_ITER - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mag;
      neg_r <= ipos[IPOS_W-1];
      div_r <= CMP_W'(ring) << (WR_STEPS - 2);
    end else if (busy_r) begin
      rem_r <= r2[IPOS_W-1:0];
      div_r <= div_r >> 2;
    end
  end

  assign res.done = done_r;
  assign res.neg  = neg_r;
  assign res.rem  = rem_r[AW-1:0];

endmodule

// ----- rtl/cmd_lane.sv -----
module cmd_lane (
  input  logic                          clk,
  input  cmd_pkg::lane_ctl_t            ctl,
  input  cmd_pkg::sample_t              x,
  input  logic [cmd_pkg::FRAC_W-1:0]    frac,
  input  logic [cmd_pkg::GAIN_W-1:0]    gain,
  input  logic [cmd_pkg::MIXC_W-1:0]    mix,
  output cmd_pkg::sample_t              y
);
  import cmd_pkg::*;

  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] wdata;

  sample_t            s1_r;
  sample_t            wet_r;
  logic signed [31:0] fbp_r;
  logic signed [34:0] mixp_r;

  logic signed [16:0] diff;
  logic signed [25:0] iprod;
  logic signed [25:0] ishift;
  sample_t            wet_nxt;
  logic signed [35:0] fbr;
  logic signed [35:0] fbs;
  logic signed [35:0] fbsum;
  logic signed [16:0] wdiff;
  logic signed [34:0] mixp_nxt;
  logic signed [35:0] acc;

  cmd_ram #(
    .W    (SAMPLE_W),
    .DEPTH(MAX_DELAY)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.we),
    .waddr(ctl.wr_addr),
    .wdata(wdata),
    .raddr(ctl.rd_addr),
    .rdata(rdata)
  );

  always_comb begin
    // wet = s1 + floor((s2 - s1) * f / 256)
    diff    = {rdata[15], rdata} - {s1_r[15], s1_r};
    iprod   = diff * $signed({1'b0, frac});
    ishift  = iprod >>> FRAC_W;
    wet_nxt = s1_r + ishift[15:0];

    fbr   = {{4{fbp_r[31]}}, fbp_r} + 36'sd16384;
    fbs   = fbr >>> 15;
    fbsum = fbs + {{20{x[15]}}, x};
    wdata = ctl.clr ? '0 : sat16(fbsum);

    // dry/wet mix as 32768*x + m*(wet - x)
    wdiff    = {wet_r[15], wet_r} - {x[15], x};
    mixp_nxt = $signed({1'b0, mix}) * wdiff;
    acc      = {{5{x[15]}}, x, 15'b0} + {mixp_r[34], mixp_r} + 36'sd16384;
    y        = sat16(acc >>> 15);
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_s1) begin
      s1_r <= rdata;
    end
    if (ctl.interp) begin
      wet_r <= wet_nxt;
    end
    if (ctl.fb) begin
      fbp_r <= $signed({1'b0, gain}) * wet_r;
    end
    if (ctl.we && !ctl.clr) begin
      mixp_r <= mixp_nxt;
    end
  end

endmodule

// ----- rtl/chorus_modulated_delay.sv -----
// Stereo chorus: each accepted word (one left/right frame) is delayed through a
// sine-modulated, linearly interpolated ring with feedback and mixed dry/wet into
// one output word. One lane per channel, each with its own delay RAM, runs in
// lockstep; the output register merges both lanes. How soon after acceptance
// the next frame can be taken is set by the serial ring-index reduction (two
// restoring steps per cycle over the read position) and the single read port of
// each delay RAM. A finished word waits in the output register while the next
// frame is taken. After reset a clearing pass zeroes both delay RAMs, one entry
// per cycle; in_ready stays low during it, configuration writes are taken.
// Configuration must be written only while the block is idle.
module chorus_modulated_delay (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cmd_pkg::sample_t                 in_left,
  input  cmd_pkg::sample_t                 in_right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cmd_pkg::sample_t                 out_left,
  output cmd_pkg::sample_t                 out_right,
  input  logic                             cfg_we,
  input  logic [cmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmd_pkg::CFG_W-1:0]        cfg_data
);
  import cmd_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_MUL    = 14'b00000000000100,
    S_DELAY  = 14'b00000000001000,
    S_POS    = 14'b00000000010000,
    S_START  = 14'b00000000100000,
    S_WRAP   = 14'b00000001000000,
    S_IDX    = 14'b00000010000000,
    S_RD1    = 14'b00000100000000,
    S_RD2    = 14'b00001000000000,
    S_INTERP = 14'b00010000000000,
    S_FB     = 14'b00100000000000,
    S_WR     = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      write_pos_r;
  logic [PHASE_W-1:0] lfo_phase_r;

  logic [BASE_W-1:0]  base_delay_r;
  logic [DEPTH_W-1:0] mod_depth_r;
  logic [STEP_W-1:0]  lfo_step_r;
  logic [GAIN_W-1:0]  feedback_gain_r;
  logic [MIX_W-1:0]   wet_mix_r;
  logic [RLEN_W-1:0]  ring_length_r;

  sample_t              x_r [0:1];
  logic [AW-1:0]        wp_r;
  logic [RING_W-1:0]    ring_r;
  logic [MIXC_W-1:0]    mix_r;
  logic signed [15:0]   sine_r;
  logic signed [35:0]   prod_r;
  logic signed [D8_W-1:0]   delay8_r;
  logic signed [IPOS_W-1:0] ipos_r;
  logic [FRAC_W-1:0]    frac_r;
  logic [AW-1:0]        i1_r;
  logic [AW-1:0]        i2_r;

  logic    out_valid_r;
  sample_t out_left_r;
  sample_t out_right_r;

  logic [RING_W-1:0]        ring_eff;
  logic [AW-1:0]            wp_sel;
  logic [MIXC_W-1:0]        mix_eff;
  logic signed [35:0]       prod_sh;
  logic signed [D8_W-1:0]   delay8_nxt;
  logic signed [POS_W-1:0]  pos8_nxt;
  logic [RING_W-1:0]        rem_ext;
  logic [RING_W-1:0]        i1_nxt;
  logic [RING_W-1:0]        i1_inc;
  logic [RING_W-1:0]        wp_inc;
  logic [AW-1:0]            wp_nxt;

  logic      accept;
  logic      load_out;
  lane_ctl_t lane_ctl;
  wrap_res_t wrap_res;
  sample_t   y [0:1];

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    if (ring_length_r == '0) begin
      ring_eff = RING_W'(1);
    end else if (32'(ring_length_r) > 32'(MAX_DELAY)) begin
      ring_eff = RING_W'(MAX_DELAY);
    end else begin
      ring_eff = RING_W'(ring_length_r);
    end
    wp_sel  = (RING_W'(write_pos_r) < ring_eff) ? write_pos_r : '0;
    mix_eff = (MIXC_W'(wet_mix_r) > MIX_ONE) ? MIX_ONE : MIXC_W'(wet_mix_r);

    prod_sh    = prod_r >>> 15;
    delay8_nxt = $signed({2'b0, base_delay_r, 8'b0}) + prod_sh[D8_W-1:0];
    pos8_nxt   = POS_W'({wp_r, 8'b0}) - POS_W'(delay8_r);

    rem_ext = RING_W'(wrap_res.rem);
    i1_nxt  = (wrap_res.neg && wrap_res.rem != '0) ? ring_r - rem_ext : rem_ext;
    i1_inc  = RING_W'(i1_r) + 1'b1;
    wp_inc  = RING_W'(wp_r) + 1'b1;
    wp_nxt  = (wp_inc == ring_r) ? '0 : wp_inc[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_cnt_r == AW'(MAX_DELAY - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DELAY;
      S_DELAY:  state_nxt = S_POS;
      S_POS:    state_nxt = S_START;
      S_START:  state_nxt = S_WRAP;
      S_WRAP:   if (wrap_res.done) state_nxt = S_IDX;
      S_IDX:    state_nxt = S_RD1;
      S_RD1:    state_nxt = S_RD2;
      S_RD2:    state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_FB;
      S_FB:     state_nxt = S_WR;
      S_WR:     state_nxt = S_OUT;
      S_OUT:    if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    lane_ctl = '0;
    unique case (state_r)
      S_CLEAR: begin
        lane_ctl.we      = 1'b1;
        lane_ctl.clr     = 1'b1;
        lane_ctl.wr_addr = clr_cnt_r;
      end
      S_RD1: lane_ctl.rd_addr = i1_r;
      S_RD2: begin
        lane_ctl.rd_addr = i2_r;
        lane_ctl.cap_s1  = 1'b1;
      end
      S_INTERP: lane_ctl.interp = 1'b1;
      S_FB:     lane_ctl.fb     = 1'b1;
      S_WR: begin
        lane_ctl.we      = 1'b1;
        lane_ctl.wr_addr = wp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      write_pos_r     <= '0;
      lfo_phase_r     <= '0;
      out_valid_r     <= 1'b0;
      base_delay_r    <= BASE_W'(882);
      mod_depth_r     <= '0;
      lfo_step_r      <= STEP_W'(9739);
      feedback_gain_r <= '0;
      wet_mix_r       <= MIX_W'(16384);
      ring_length_r   <= RLEN_W'(1000);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_DELAY:    base_delay_r    <= cfg_data[BASE_W-1:0];
          CFG_MOD_DEPTH:     mod_depth_r     <= cfg_data[DEPTH_W-1:0];
          CFG_LFO_STEP:      lfo_step_r      <= cfg_data[STEP_W-1:0];
          CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[GAIN_W-1:0];
          CFG_WET_MIX:       wet_mix_r       <= cfg_data[MIX_W-1:0];
          CFG_RING_LENGTH:   ring_length_r   <= cfg_data[RLEN_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        write_pos_r <= wp_nxt;
        lfo_phase_r <= lfo_phase_r + PHASE_W'(lfo_step_r);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r[0] <= in_left;
      x_r[1] <= in_right;
      wp_r   <= wp_sel;
      ring_r <= ring_eff;
      mix_r  <= mix_eff;
      sine_r <= lfo_sine(lfo_phase_r[PHASE_W-1 -: 8]);
    end
    if (state_r == S_MUL) begin
      prod_r <= $signed({1'b0, mod_depth_r}) * sine_r;
    end
    if (state_r == S_DELAY) begin
      delay8_r <= delay8_nxt;
    end
    if (state_r == S_POS) begin
      ipos_r <= pos8_nxt[POS_W-1:FRAC_W];
      frac_r <= pos8_nxt[FRAC_W-1:0];
    end
    if (state_r == S_IDX) begin
      i1_r <= i1_nxt[AW-1:0];
    end
    if (state_r == S_RD1) begin
      i2_r <= (i1_inc == ring_r) ? '0 : i1_inc[AW-1:0];
    end
    if (load_out) begin
      out_left_r  <= y[0];
      out_right_r <= y[1];
    end
  end

  cmd_wrap u_wrap (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == S_START),
    .ipos (ipos_r),
    .ring (ring_r),
    .res  (wrap_res)
  );

  for (genvar g = 0; g < 2; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      cmd_lane u_lane (
        .clk (clk),
        .ctl (lane_ctl),
        .x   (x_r[g]),
        .frac(frac_r),
        .gain(feedback_gain_r),
        .mix (mix_r),
        .y   (y[g])
      );
    end else begin : g_off
      assign y[g] = '0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

// ----- rtl/cmd_chk.sv -----
module cmd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_left,
  input logic [15:0] out_right
);

  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a word");

  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0) && (pend_r != 2'd3))
    else $error("output word without a matching input word");

  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during delay store clear");

endmodule

bind chorus_modulated_delay cmd_chk u_cmd_chk (.*);

// ----- tb/sv/chorus_modulated_delay_tb.sv -----
module chorus_modulated_delay_tb;
  import cmd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  localparam int SINE_QTR [0:64] = '{
    0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179, 7962, 8739,
    9512, 10278, 11039, 11793, 12539, 13279, 14010, 14732, 15446, 16151,
    16846, 17530, 18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
    23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790, 27245, 27683,
    28105, 28510, 28898, 29268, 29621, 29956, 30273, 30571, 30852, 31113,
    31356, 31580, 31785, 31971, 32137, 32285, 32412, 32521, 32609, 32678,
    32728, 32757, 32767
  };

  typedef struct {
    sample_t left;
    sample_t right;
  } mixed_frame_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sample_t              in_left;
  sample_t              in_right;
  logic                 out_valid;
  logic                 out_ready;
  sample_t              out_left;
  sample_t              out_right;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  sample_t            tap_mem [2][MAX_DELAY];
  int                 wr_idx;
  logic [PHASE_W-1:0] phase_q;
  logic [BASE_W-1:0]  base_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [STEP_W-1:0]  step_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [MIX_W-1:0]   mix_q;
  logic [RLEN_W-1:0]  ring_q;

  mixed_frame_t expected_frames [$];
  mixed_frame_t head;

  int  n_frames;
  int  n_words;
  int  n_err;
  int  n_settings;
  int  cycle_count;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_req;
  int  hold_len;

  chorus_modulated_delay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_left   (in_left),
    .in_right  (in_right),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left),
    .out_right (out_right),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int lfo_value(logic [PHASE_W-1:0] ph);
    logic [7:0] idx;
    idx = ph[31:24];
    case (idx[7:6])
      2'd0: return SINE_QTR[idx[5:0]];
      2'd1: return SINE_QTR[64 - idx[5:0]];
      2'd2: return -SINE_QTR[idx[5:0]];
      default: return -SINE_QTR[64 - idx[5:0]];
    endcase
  endfunction

  function automatic sample_t clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // interpolated tap, feedback write-back and dry/wet mix for one channel
  function automatic sample_t tap_and_mix(int ch, longint x, longint d8, int ring, int wp,
                                          longint mix);
    longint len8, pos, s1, s2, wet, fb, o;
    int     i1, i2, f;
    len8 = longint'(ring) * 256;
    pos  = (longint'(wp) * 256 - d8) % len8;
    if (pos < 0) pos += len8;
    i1  = int'(pos >> 8) % ring;
    i2  = (i1 + 1) % ring;
    f   = int'(pos & 255);
    s1  = tap_mem[ch][i1];
    s2  = tap_mem[ch][i2];
    wet = (s1 * (256 - f) + s2 * f) >>> 8;
    fb  = x + ((longint'(gain_q) * wet + 16384) >>> 15);
    tap_mem[ch][wp] = clip16(fb);
    o = (32768 - mix) * x + mix * wet + 16384;
    return clip16(o >>> 15);
  endfunction

  function automatic void predict_frame(sample_t l, sample_t r);
    int           ring, wp;
    longint       mix, d8;
    mixed_frame_t e;
    ring = ring_q;
    if (ring < 1) ring = 1;
    if (ring > MAX_DELAY) ring = MAX_DELAY;
    mix = (mix_q > 32768) ? 32768 : mix_q;
    wp  = (wr_idx < ring) ? wr_idx : 0;
    d8  = longint'(base_q) * 256 + ((longint'(depth_q) * lfo_value(phase_q)) >>> 15);
    e.left  = tap_and_mix(0, l, d8, ring, wp, mix);
    e.right = tap_and_mix(1, r, d8, ring, wp, mix);
    expected_frames.push_back(e);
    wr_idx  = (wp + 1) % ring;
    phase_q = phase_q + step_q;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_BASE_DELAY:    base_q  = val[BASE_W-1:0];
      CFG_MOD_DEPTH:     depth_q = val[DEPTH_W-1:0];
      CFG_LFO_STEP:      step_q  = val[STEP_W-1:0];
      CFG_FEEDBACK_GAIN: gain_q  = val[GAIN_W-1:0];
      CFG_WET_MIX:       mix_q   = val[MIX_W-1:0];
      CFG_RING_LENGTH:   ring_q  = val[RLEN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    foreach (tap_mem[c, i]) tap_mem[c][i] = '0;
    wr_idx  = 0;
    phase_q = '0;
    base_q  = 882;
    depth_q = 0;
    step_q  = 9739;
    gain_q  = 0;
    mix_q   = 16384;
    ring_q  = 1000;
  endfunction

  // checker: output words against the oldest prediction, then track inputs and writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_words++;
        if (expected_frames.size() == 0) begin
          if (n_err < 10)
            $display("unexpected word %0d: L=%0d R=%0d", n_words, out_left, out_right);
          n_err++;
        end else begin
          head = expected_frames.pop_front();
          if (out_left !== head.left || out_right !== head.right) begin
            if (n_err < 10)
              $display("mismatch word %0d: exp L=%0d R=%0d got L=%0d R=%0d",
                       n_words, head.left, head.right, out_left, out_right);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) predict_frame(in_left, in_right);
      if (cfg_we) apply_config(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_frames.size());
      $display("chorus_modulated_delay_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_frame(input sample_t l, input sample_t r);
    int gap;
    gap = 0;
    while (tx_idle && $urandom_range(0, 2) == 0) gap += $urandom_range(1, 5);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_left  = l;
    in_right = r;
    do @(posedge clk); while (!in_ready);
    n_frames++;
  endtask

  // drop valid and wait until every word is back and the block takes input again
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_frames.size() != 0 || !in_ready) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] depth,
                               input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] mix, input logic [CFG_W-1:0] ring);
    wait_idle();
    write_reg(CFG_BASE_DELAY, base);
    write_reg(CFG_MOD_DEPTH, depth);
    write_reg(CFG_LFO_STEP, step);
    write_reg(CFG_FEEDBACK_GAIN, gain);
    write_reg(CFG_WET_MIX, mix);
    write_reg(CFG_RING_LENGTH, ring);
    n_settings++;
  endtask

  function automatic sample_t any_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 511)) - 16'sd256;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // power-on values: wet tap still reads cleared store
  task automatic test_reset_state();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(-16'sd1, 16'sd0);
    send_frame(16'sd0, -16'sd1);
    wait_idle();
  endtask

  task automatic test_feedback_saturation();
    load_settings(1, 0, 1, 32767, 32768, 4);
    repeat (3) send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh5555, -16'sh2aab);
    send_frame(16'sd1, -16'sd2);
    wait_idle();
  endtask

  task automatic test_ring_limits();
    // ring of zero clamps to one, zero delay reads the slot before it is written,
    // and the old write index lies beyond the shortened ring
    load_settings(0, 0, 3, 16384, 32768, 0);
    send_frame(16'sd1000, -16'sd1000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(-16'sd7, 16'sd7);
    // oversize ring, delay longer than the ring, wet share above one
    load_settings(4095, 19'h7ffff, 31'h7fffffff, 32440, 65535, 8191);
    repeat (4) send_frame(any_sample(), any_sample());
    // quarter-turn LFO with full depth around zero base gives negative delays
    load_settings(0, 19'h7ffff, 32'h4000_0000, 0, 0, 64);
    repeat (6) send_frame(any_sample(), any_sample());
    wait_idle();
  endtask

  task automatic test_output_stall();
    load_settings(20, 2560, 400000, 16000, 20000, 48);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_len = 400;
    hold_req = 1'b1;
    repeat (40) send_frame(any_sample(), any_sample());
    wait_idle();
  endtask

  task automatic test_random_phase(input int frames, input bit idling);
    logic [CFG_W-1:0] ring, base, depth, step, gain, mix;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) ring = $urandom_range(2, 64);
    else if (pick < 8) ring = $urandom_range(65, 4096);
    else if (pick == 8) ring = $urandom_range(0, 1);
    else ring = $urandom_range(4097, 8191);
    if ($urandom_range(0, 3) != 0) base = $urandom_range(0, (ring > 4095) ? 4095 : ring);
    else base = $urandom_range(0, 4095);
    case ($urandom_range(0, 5))
      0: depth = 0;
      1: depth = 19'h7ffff;
      default: depth = $urandom_range(0, ring * 256) & 19'h7ffff;
    endcase
    step = ($urandom_range(0, 1) != 0) ? ($urandom & 31'h7fffffff) : $urandom_range(1, 1 << 20);
    case ($urandom_range(0, 3))
      0: gain = 0;
      1: gain = 32767;
      default: gain = $urandom_range(0, 32767);
    endcase
    case ($urandom_range(0, 4))
      0: mix = 0;
      1: mix = 32768;
      default: mix = $urandom_range(0, 65535);
    endcase
    load_settings(base, depth, step, gain, mix, ring);
    tx_idle = idling;
    rx_idle = idling;
    repeat (frames) send_frame(any_sample(), any_sample());
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_left   = '0;
    in_right  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BASE_DELAY;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_req  = 1'b0;
    hold_len  = 0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_feedback_saturation();
    test_ring_limits();
    test_output_stall();
    repeat (6) test_random_phase(250, 1'b1);
    repeat (2) test_random_phase(250, 1'b0);

    wait_idle();
    repeat (64) @(posedge clk);
    $display("%0d frames in, %0d words out, %0d register settings incl. clamped rings,",
             n_frames, n_words, n_settings);
    $display("saturating feedback, negative and wrapped delays and a long output stall");
    if (n_err == 0 && expected_frames.size() == 0) begin
      $display("chorus_modulated_delay_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d words never arrived", n_err, expected_frames.size());
      $display("chorus_modulated_delay_tb: done, errors");
    end
    $finish;
  end

endmodule
